// ----- design/daq_subpacket_deframer_defines.svh -----
// ----------------------------------------------------------------------------
// Subpacket deframer assertion macros
// Shared helpers for the concurrent checks of the deframer modules.
// ----------------------------------------------------------------------------
`ifndef DAQ_SUBPACKET_DEFRAMER_DEFINES_SVH
`define DAQ_SUBPACKET_DEFRAMER_DEFINES_SVH

// The using module must have aclk and aresetn in scope.
`define DSD_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("deframer check failed");

`define DSD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("deframer check failed");

`endif

// ----- design/dsd_pkg.sv -----
// ----------------------------------------------------------------------------
// Subpacket deframer package
// Types and constants shared by the deframer lanes, result queue and top level.
// ----------------------------------------------------------------------------
package dsd_pkg;

    localparam logic [5:0]  NO_RUN       = 6'h3f;
    localparam logic [31:0] MARKER_WORD  = 32'hffff_ffff;
    localparam logic [7:0]  MARKER_MAX   = 8'hff;

    localparam int SIZE_LSB = 46;
    localparam int PT_BIT   = 45;

    localparam logic [5:0] CHANNELS_RESET = 6'd37;
    localparam logic [5:0] BLOCK_RESET    = 6'd39;

    // Register index is taken from paddr[2].
    localparam logic REG_CHANNELS_PER_ERX = 1'b0;
    localparam logic REG_ERX_BLOCK_WORDS  = 1'b1;

    // Result queue depth, pointer width and count width.
    localparam int RQ_DEPTH = 8;
    localparam int RQ_PTR_W = 3;
    localparam int RQ_CNT_W = 4;

    typedef enum logic [2:0] {
        PH_SUBHDR  = 3'b001,
        PH_EVHDR   = 3'b010,
        PH_PAYLOAD = 3'b100
    } phase_t;

    typedef struct packed {
        logic        is_status;
        logic [3:0]  source_index;
        logic [3:0]  erx_index;
        logic [5:0]  channel_index;
        logic [31:0] channel_data;
        logic        payload_ok;
        logic [7:0]  marker_total;
        logic        end_of_run;
    } result_t;

    typedef struct packed {
        logic       emit;
        logic [3:0] erx_index;
        logic [5:0] channel_index;
        logic [7:0] marker_count;
        logic [5:0] channel_count;
    } lane_out_t;

endpackage

// ----- design/daq_subpacket_deframer.sv -----
// ----------------------------------------------------------------------------
// Subpacket deframer top level
// Splits event fragment words into channel results and payload status results.
// ----------------------------------------------------------------------------
// One 64-bit fragment word is accepted per cycle; its two 32-bit halves go
// through two chained lanes, high half first, in that same cycle. A word gives
// zero to three results (two channel words and one status), registered in an
// eight-entry result queue that drains one result per cycle while the output
// is ready. The input stays ready while the queue holds at most five results,
// so the input rate is one word per cycle as long as the output takes results
// at least as fast as the words cause them; words giving more than one result
// fill the queue faster than it drains. Configuration sits on an APB port:
// channels_per_erx at byte address 0 and erx_block_words at byte address 4,
// which the user must write only while the block is idle; it is not enforced.
`include "daq_subpacket_deframer_defines.svh"

module daq_subpacket_deframer import dsd_pkg::*; #(
    parameter int MAX_SOURCES = 12
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // word[63:0]
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // source_index[3:0], erx_index[7:4], channel_index[13:8],
    // channel_data[45:14], payload_ok[46], marker_total[54:47], zero pad[55]
    output logic [55:0] m_axis_tdata,
    output logic [0:0]  m_axis_tuser,   // is_status[0]
    output logic        m_axis_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int SRC_W = $clog2(MAX_SOURCES + 1);

    // Configuration registers.
    logic [5:0] channels_per_erx_reg;
    logic [5:0] erx_block_words_reg;

    // Deframing state.
    phase_t            phase_reg, phase_next;
    logic [SRC_W-1:0]  valid_sources_reg, valid_sources_next;
    logic [SRC_W-1:0]  source_counter_reg, source_counter_next;
    logic [8:0]        words_left_reg, words_left_next;
    logic [8:0]        words_total_reg, words_total_next;
    logic              pass_through_reg, pass_through_next;
    logic [7:0]        marker_count_reg, marker_count_next;
    logic [5:0]        channel_count_reg, channel_count_next;

    logic              s_acc;
    logic              space_ok;
    logic [SRC_W-1:0]  src_found;
    logic [SRC_W:0]    src_inc;
    logic [9:0]        size_plus;
    logic [8:0]        header_words;
    logic              lanes_active;
    lane_out_t         lane_hi, lane_lo;
    logic [13:0]       mark_prod;
    logic [14:0]       mark_prod_hi;
    logic [9:0]        expect_span;
    logic              block_ok;
    logic              status_en;
    logic              status_ok;
    logic [7:0]        status_markers;
    logic              emit_hi, emit_lo;
    result_t           item_hi, item_lo, item_st;
    result_t           push_data [3];
    logic [1:0]        push_cnt;
    result_t           out_item;

    assign s_axis_tready = space_ok;
    assign s_acc         = s_axis_tvalid && space_ok;
    assign pready        = 1'b1;

    // ---------------- configuration port ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            channels_per_erx_reg <= CHANNELS_RESET;
            erx_block_words_reg  <= BLOCK_RESET;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[2])
                REG_CHANNELS_PER_ERX: channels_per_erx_reg <= pwdata[5:0];
                REG_ERX_BLOCK_WORDS:  erx_block_words_reg  <= pwdata[5:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_CHANNELS_PER_ERX: prdata = {26'd0, channels_per_erx_reg};
            REG_ERX_BLOCK_WORDS:  prdata = {26'd0, erx_block_words_reg};
            default:              prdata = '0;
        endcase
    end

    // ---------------- subpacket header decode ----------------
    always_comb begin
        src_found = '0;
        for (int i = 0; i < MAX_SOURCES; i++) begin
            src_found = src_found + SRC_W'(s_axis_tdata[3*i +: 2] == 2'b00);
        end
    end

    assign src_inc      = {1'b0, source_counter_reg} + (SRC_W+1)'(1);
    assign size_plus    = {1'b0, s_axis_tdata[SIZE_LSB +: 9]} + 10'd1;
    assign header_words = size_plus[9:1];

    // ---------------- lanes: high half first ----------------
    assign lanes_active = (phase_reg == PH_PAYLOAD) && pass_through_reg;

    dsd_lane u_lane_hi (
        .active           (lanes_active),
        .half             (s_axis_tdata[63:32]),
        .channels_per_erx (channels_per_erx_reg),
        .marker_in        (marker_count_reg),
        .channel_in       (channel_count_reg),
        .lane_out         (lane_hi)
    );

    dsd_lane u_lane_lo (
        .active           (lanes_active),
        .half             (s_axis_tdata[31:0]),
        .channels_per_erx (channels_per_erx_reg),
        .marker_in        (lane_hi.marker_count),
        .channel_in       (lane_hi.channel_count),
        .lane_out         (lane_lo)
    );

    // The marker count matches floor((2W-2)/B) exactly when
    // M*B <= 2W-2 < M*B + B.
    assign mark_prod    = lane_lo.marker_count * erx_block_words_reg;
    assign mark_prod_hi = {1'b0, mark_prod} + {9'd0, erx_block_words_reg};
    assign expect_span  = {words_total_reg, 1'b0} - 10'd2;
    assign block_ok     = (words_total_reg != 9'd0) && (erx_block_words_reg != 6'd0) &&
                          ({4'd0, expect_span} >= mark_prod) &&
                          ({5'd0, expect_span} < mark_prod_hi);

    // ---------------- state update ----------------
    always_comb begin
        phase_next          = phase_reg;
        valid_sources_next  = valid_sources_reg;
        source_counter_next = source_counter_reg;
        words_left_next     = words_left_reg;
        words_total_next    = words_total_reg;
        pass_through_next   = pass_through_reg;
        marker_count_next   = marker_count_reg;
        channel_count_next  = channel_count_reg;
        status_en           = 1'b0;
        status_ok           = 1'b0;
        status_markers      = 8'd0;
        emit_hi             = 1'b0;
        emit_lo             = 1'b0;
        if (s_acc) begin
            unique case (phase_reg)
                PH_EVHDR: begin
                    pass_through_next  = s_axis_tdata[PT_BIT];
                    words_total_next   = header_words;
                    words_left_next    = header_words;
                    marker_count_next  = 8'd0;
                    channel_count_next = NO_RUN;
                    if (header_words == 9'd0) begin
                        status_en           = s_axis_tdata[PT_BIT];
                        source_counter_next = src_inc[SRC_W-1:0];
                        phase_next = (src_inc >= {1'b0, valid_sources_reg}) ?
                                     PH_SUBHDR : PH_EVHDR;
                    end else begin
                        phase_next = PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD: begin
                    emit_hi            = lane_hi.emit;
                    emit_lo            = lane_lo.emit;
                    marker_count_next  = lane_lo.marker_count;
                    channel_count_next = lane_lo.channel_count;
                    status_ok          = block_ok;
                    status_markers     = lane_lo.marker_count;
                    words_left_next    = words_left_reg - 9'd1;
                    if (words_left_reg == 9'd1) begin
                        channel_count_next  = NO_RUN;
                        status_en           = pass_through_reg;
                        source_counter_next = src_inc[SRC_W-1:0];
                        phase_next = (src_inc >= {1'b0, valid_sources_reg}) ?
                                     PH_SUBHDR : PH_EVHDR;
                    end else begin
                        status_en = s_axis_tlast && pass_through_reg;
                    end
                end
                default: begin
                    valid_sources_next  = src_found;
                    source_counter_next = '0;
                    phase_next = (src_found == '0) ? PH_SUBHDR : PH_EVHDR;
                end
            endcase
            if (s_axis_tlast) begin
                phase_next          = PH_SUBHDR;
                valid_sources_next  = '0;
                source_counter_next = '0;
                words_left_next     = '0;
                words_total_next    = '0;
                pass_through_next   = 1'b0;
                marker_count_next   = 8'd0;
                channel_count_next  = NO_RUN;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg          <= PH_SUBHDR;
            valid_sources_reg  <= '0;
            source_counter_reg <= '0;
            words_left_reg     <= '0;
            words_total_reg    <= '0;
            pass_through_reg   <= 1'b0;
            marker_count_reg   <= 8'd0;
            channel_count_reg  <= NO_RUN;
        end else begin
            phase_reg          <= phase_next;
            valid_sources_reg  <= valid_sources_next;
            source_counter_reg <= source_counter_next;
            words_left_reg     <= words_left_next;
            words_total_reg    <= words_total_next;
            pass_through_reg   <= pass_through_next;
            marker_count_reg   <= marker_count_next;
            channel_count_reg  <= channel_count_next;
        end
    end

    // ---------------- merge lanes and status into the queue ----------------
    always_comb begin
        item_hi               = '0;
        item_hi.source_index  = 4'(source_counter_reg);
        item_hi.erx_index     = lane_hi.erx_index;
        item_hi.channel_index = lane_hi.channel_index;
        item_hi.channel_data  = s_axis_tdata[63:32];
        item_hi.end_of_run    = !emit_lo && !status_en;

        item_lo               = '0;
        item_lo.source_index  = 4'(source_counter_reg);
        item_lo.erx_index     = lane_lo.erx_index;
        item_lo.channel_index = lane_lo.channel_index;
        item_lo.channel_data  = s_axis_tdata[31:0];
        item_lo.end_of_run    = !status_en;

        item_st               = '0;
        item_st.is_status     = 1'b1;
        item_st.source_index  = 4'(source_counter_reg);
        item_st.payload_ok    = status_ok;
        item_st.marker_total  = status_markers;
        item_st.end_of_run    = 1'b1;

        push_data[0] = emit_hi ? item_hi : (emit_lo ? item_lo : item_st);
        push_data[1] = (emit_hi && emit_lo) ? item_lo : item_st;
        push_data[2] = item_st;
        push_cnt     = 2'(emit_hi) + 2'(emit_lo) + 2'(status_en);
    end

    dsd_result_fifo u_result_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push_cnt  (push_cnt),
        .push_data (push_data),
        .space_ok  (space_ok),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (out_item)
    );

    assign m_axis_tdata = {1'b0, out_item.marker_total, out_item.payload_ok,
                           out_item.channel_data, out_item.channel_index,
                           out_item.erx_index, out_item.source_index};
    assign m_axis_tuser = out_item.is_status;
    assign m_axis_tlast = out_item.end_of_run;

    `DSD_ASSERT_NEXT(a_last_resets, s_acc && s_axis_tlast,
                     phase_reg == PH_SUBHDR && marker_count_reg == 8'd0)
    `DSD_ASSERT_IMPL(a_payload_left, phase_reg == PH_PAYLOAD, words_left_reg != 9'd0)
    `DSD_ASSERT_IMPL(a_source_range, phase_reg == PH_EVHDR,
                     source_counter_reg < valid_sources_reg)
    `DSD_ASSERT_IMPL(a_status_pt, status_en && phase_reg == PH_PAYLOAD, pass_through_reg)

endmodule

// ----- design/dsd_lane.sv -----
// ----------------------------------------------------------------------------
// Subpacket deframer lane
// Handles one 32-bit half: marker detection and channel run bookkeeping.
// ----------------------------------------------------------------------------
module dsd_lane import dsd_pkg::*; (
    input  logic        active,
    input  logic [31:0] half,
    input  logic [5:0]  channels_per_erx,
    input  logic [7:0]  marker_in,
    input  logic [5:0]  channel_in,
    output lane_out_t   lane_out
);

    logic [5:0] channel_inc;

    assign channel_inc = channel_in + 6'd1;

    always_comb begin
        lane_out.emit          = 1'b0;
        lane_out.erx_index     = 4'(marker_in - 8'd1);
        lane_out.channel_index = channel_in;
        lane_out.marker_count  = marker_in;
        lane_out.channel_count = channel_in;
        if (active) begin
            if (half == MARKER_WORD) begin
                if (marker_in != MARKER_MAX) begin
                    lane_out.marker_count = marker_in + 8'd1;
                end
                lane_out.channel_count = (channels_per_erx == 6'd0) ? NO_RUN : 6'd0;
            end else if (channel_in != NO_RUN && channel_in < channels_per_erx) begin
                lane_out.emit          = 1'b1;
                lane_out.channel_count =
                    (channel_inc >= channels_per_erx) ? NO_RUN : channel_inc;
            end
        end
    end

endmodule

// ----- design/dsd_result_fifo.sv -----
// ----------------------------------------------------------------------------
// Subpacket deframer result queue
// Takes up to three results per cycle and hands them out one per cycle while out_ready is high.
// ----------------------------------------------------------------------------
`include "daq_subpacket_deframer_defines.svh"

module dsd_result_fifo import dsd_pkg::*; (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic [1:0]    push_cnt,
    input  result_t       push_data [3],
    output logic          space_ok,
    output logic          out_valid,
    input  logic          out_ready,
    output result_t       out_data
);

    result_t               mem_reg [RQ_DEPTH];
    logic [RQ_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [RQ_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [RQ_CNT_W-1:0]   count_reg, count_next;
    logic                  pop;

    assign out_valid = (count_reg != '0);
    assign out_data  = mem_reg[rd_ptr_reg];
    assign pop       = out_valid && out_ready;
    // Room for the largest burst a single word can cause.
    assign space_ok  = (count_reg <= RQ_CNT_W'(RQ_DEPTH - 3));

    assign wr_ptr_next = wr_ptr_reg + RQ_PTR_W'(push_cnt);
    assign rd_ptr_next = rd_ptr_reg + RQ_PTR_W'(pop);
    assign count_next  = count_reg + RQ_CNT_W'(push_cnt) - RQ_CNT_W'(pop);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        for (int k = 0; k < 3; k++) begin
            if (2'(k) < push_cnt) begin
                mem_reg[wr_ptr_reg + RQ_PTR_W'(k)] <= push_data[k];
            end
        end
    end

    `DSD_ASSERT_IMPL(a_count_bound, 1'b1, count_reg <= RQ_CNT_W'(RQ_DEPTH))
    `DSD_ASSERT_IMPL(a_push_room, push_cnt != 2'd0, space_ok)
    `DSD_ASSERT_NEXT(a_pop_drains, pop && push_cnt == 2'd0,
                     count_reg == $past(count_reg) - RQ_CNT_W'(1))

endmodule

// ----- tb/daq_subpacket_deframer_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Subpacket deframer regression
// Drives fragment words into the deframer and checks every channel and status
// result against a cycle-free prediction of the framing, under idle, stall,
// hold-off and configuration changes.
// ----------------------------------------------------------------------------
module daq_subpacket_deframer_test;
    import dsd_pkg::*;

    localparam int SOURCES      = 12;
    localparam int IDLE_SLACK   = 16;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int PHASE_WORDS  = 30;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata = '0;
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [55:0] m_axis_tdata;
    logic [0:0]  m_axis_tuser;
    logic        m_axis_tlast;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    // Predictor state and register copies.
    phase_t      frm_phase;
    int unsigned n_sources;
    int unsigned src_idx;
    int unsigned words_left;
    int unsigned words_total;
    int unsigned markers;
    int          chan_pos;
    logic        pass_thru;
    logic [5:0]  cfg_channels;
    logic [5:0]  cfg_block;

    result_t     word_results[$];
    result_t     expected_results[$];
    logic [64:0] frag_words[$];     // {last, word}

    int errors = 0;
    int cycle_count = 0;
    int words_sent = 0;
    int send_idle_pct = 0;
    int stall_pct = 0;
    int hold_off_cycles = 0;

    always #1 aclk = ~aclk;

    daq_subpacket_deframer DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch on %s: got %0h, expected %0h at cycle %0d",
                 what, got, want, cycle_count);
        errors++;
    endtask

    // ------------------------------------------------------------------
    // Framing predictor
    // ------------------------------------------------------------------
    task automatic reset_framing();
        frm_phase   = PH_SUBHDR;
        n_sources   = 0;
        src_idx     = 0;
        words_left  = 0;
        words_total = 0;
        pass_thru   = 1'b0;
        markers     = 0;
        chan_pos    = NO_RUN;
    endtask

    function automatic result_t status_result();
        result_t     r;
        int unsigned needed;
        r = '0;
        r.is_status    = 1'b1;
        r.source_index = 4'(src_idx);
        r.marker_total = 8'(markers);
        if (words_total > 0 && cfg_block != 0) begin
            needed = (2 * words_total - 2) / cfg_block;
            r.payload_ok = (markers == needed);
        end
        return r;
    endfunction

    task automatic take_half(input logic [31:0] half);
        result_t r;
        if (half == MARKER_WORD) begin
            if (markers < 255) markers++;
            chan_pos = (cfg_channels == 0) ? NO_RUN : 0;
        end else if (chan_pos != NO_RUN && chan_pos < cfg_channels) begin
            r = '0;
            r.source_index  = 4'(src_idx);
            r.erx_index     = 4'(markers - 1);
            r.channel_index = 6'(chan_pos);
            r.channel_data  = half;
            word_results.insert(word_results.size(), r);
            chan_pos++;
            if (chan_pos >= cfg_channels) chan_pos = NO_RUN;
        end
    endtask

    task automatic next_source();
        src_idx++;
        frm_phase = (src_idx >= n_sources) ? PH_SUBHDR : PH_EVHDR;
    endtask

    task automatic deframe_word(input logic [63:0] w, input logic l);
        int unsigned size;
        int unsigned n;
        word_results.delete();
        case (frm_phase)
            PH_EVHDR: begin
                size        = 32'(w[SIZE_LSB +: 9]);
                pass_thru   = w[PT_BIT];
                words_total = (size + 1) / 2;
                words_left  = words_total;
                markers     = 0;
                chan_pos    = NO_RUN;
                if (words_total == 0) begin
                    if (pass_thru) word_results.insert(word_results.size(), status_result());
                    next_source();
                end else begin
                    frm_phase = PH_PAYLOAD;
                end
            end
            PH_PAYLOAD: begin
                if (pass_thru) begin
                    take_half(w[63:32]);
                    take_half(w[31:0]);
                end
                if (words_left > 0) words_left--;
                if (words_left == 0) begin
                    chan_pos = NO_RUN;
                    if (pass_thru) word_results.insert(word_results.size(), status_result());
                    next_source();
                end else if (l && pass_thru) begin
                    // A cut payload still reports against its full size.
                    word_results.insert(word_results.size(), status_result());
                end
            end
            default: begin
                n = 0;
                for (int i = 0; i < SOURCES; i++) begin
                    if (w[3 * i +: 2] == 2'b00) n++;
                end
                n_sources = n;
                src_idx   = 0;
                frm_phase = (n == 0) ? PH_SUBHDR : PH_EVHDR;
            end
        endcase
        if (l) reset_framing();
        if (word_results.size() > 0) word_results[word_results.size() - 1].end_of_run = 1'b1;
        foreach (word_results[i]) expected_results.insert(expected_results.size(), word_results[i]);
    endtask

    // ------------------------------------------------------------------
    // Result channel: stall pattern, hold-off and checking
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (hold_off_cycles > 0) begin
            m_axis_tready <= 1'b0;
            hold_off_cycles--;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge aclk) begin
        result_t got;
        result_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got.is_status     = m_axis_tuser[0];
            got.source_index  = m_axis_tdata[3:0];
            got.erx_index     = m_axis_tdata[7:4];
            got.channel_index = m_axis_tdata[13:8];
            got.channel_data  = m_axis_tdata[45:14];
            got.payload_ok    = m_axis_tdata[46];
            got.marker_total  = m_axis_tdata[54:47];
            got.end_of_run    = m_axis_tlast;
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected result", 64'(m_axis_tdata), '0);
            end else begin
                want = expected_results.pop_front();
                if (got.is_status != want.is_status)
                    report_mismatch("is_status", 64'(got.is_status),
                                    64'(want.is_status));
                if (got.source_index != want.source_index)
                    report_mismatch("source_index", 64'(got.source_index),
                                    64'(want.source_index));
                if (got.erx_index != want.erx_index)
                    report_mismatch("erx_index", 64'(got.erx_index),
                                    64'(want.erx_index));
                if (got.channel_index != want.channel_index)
                    report_mismatch("channel_index", 64'(got.channel_index),
                                    64'(want.channel_index));
                if (got.channel_data != want.channel_data)
                    report_mismatch("channel_data", 64'(got.channel_data),
                                    64'(want.channel_data));
                if (got.payload_ok != want.payload_ok)
                    report_mismatch("payload_ok", 64'(got.payload_ok),
                                    64'(want.payload_ok));
                if (got.marker_total != want.marker_total)
                    report_mismatch("marker_total", 64'(got.marker_total),
                                    64'(want.marker_total));
                if (got.end_of_run != want.end_of_run)
                    report_mismatch("end_of_run", 64'(got.end_of_run),
                                    64'(want.end_of_run));
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("daq_subpacket_deframer regression: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Input side and configuration
    // ------------------------------------------------------------------
    task automatic send_word(input logic [63:0] w, input logic l);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= w;
        s_axis_tlast  <= l;
        do @(posedge aclk); while (!s_axis_tready);
        deframe_word(w, l);
        words_sent++;
    endtask

    // Drops the valid and waits until every expected result has come out.
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (IDLE_SLACK) @(posedge aclk);
    endtask

    task automatic apb_write(input logic reg_sel, input logic [5:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_sel, 2'b00};
        pwdata  <= {26'd0, value};
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (reg_sel == REG_CHANNELS_PER_ERX) cfg_channels = value;
        else cfg_block = value;
        // Leave the bus idle before the next transfer.
        @(posedge aclk);
    endtask

    task automatic set_config(input int channels, input int block_words);
        wait_idle();
        apb_write(REG_CHANNELS_PER_ERX, 6'(channels));
        apb_write(REG_ERX_BLOCK_WORDS, 6'(block_words));
    endtask

    // ------------------------------------------------------------------
    // Fragment building
    // ------------------------------------------------------------------
    task automatic push_word(input logic [63:0] w);
        frag_words.insert(frag_words.size(), {1'b0, w});
    endtask

    function automatic logic [63:0] source_header(input int n_valid);
        logic [63:0] w;
        int          picked;
        int          slot;
        w = {$urandom, $urandom};
        for (slot = 0; slot < SOURCES; slot++) w[3 * slot +: 2] = 2'($urandom_range(1, 3));
        picked = 0;
        while (picked < n_valid) begin
            slot = $urandom_range(0, SOURCES - 1);
            if (w[3 * slot +: 2] != 2'b00) begin
                w[3 * slot +: 2] = 2'b00;
                picked++;
            end
        end
        return w;
    endfunction

    function automatic logic [63:0] event_header(input int size, input logic pt);
        logic [63:0] w;
        w = {$urandom, $urandom};
        w[SIZE_LSB +: 9] = 9'(size);
        w[PT_BIT] = pt;
        return w;
    endfunction

    // Markers open each block of block_words halves after the two leading
    // halves; noise adds stray markers, zeros and near-marker values.
    task automatic add_payload(input int n_words, input int n_blocks, input int block_words,
                               input int noise_pct);
        logic [63:0] w;
        logic [31:0] half;
        int          roll;
        for (int h = 0; h < 2 * n_words; h++) begin
            roll = $urandom_range(99);
            if (roll < noise_pct) half = MARKER_WORD;
            else if (roll < noise_pct + 3) half = '0;
            else if (roll < noise_pct + 6) half = MARKER_WORD - 1;
            else half = $urandom;
            if (block_words > 0 && h >= 2 && (h - 2) % block_words == 0
                    && (h - 2) / block_words < n_blocks)
                half = MARKER_WORD;
            if (h % 2 == 0) begin
                w[63:32] = half;
            end else begin
                w[31:0] = half;
                push_word(w);
            end
        end
    endtask

    task automatic send_fragment(input int keep);
        while (frag_words.size() > keep) void'(frag_words.pop_back());
        frag_words[frag_words.size() - 1][64] = 1'b1;
        foreach (frag_words[i]) send_word(frag_words[i][63:0], frag_words[i][64]);
        frag_words.delete();
    endtask

    function automatic int block_payload_words(input int n_blocks, input int block_words);
        int n;
        n = (n_blocks * block_words + 3) / 2;
        return (n > 256) ? 256 : n;
    endfunction

    task automatic random_fragment();
        int   n_valid;
        int   n_words;
        int   n_blocks;
        int   size;
        int   keep;
        int   roll;
        logic pt;
        roll = $urandom_range(99);
        if (roll < 6) begin
            repeat ($urandom_range(1, 6)) push_word({$urandom, $urandom});
        end else begin
            repeat ($urandom_range(1, 2)) begin
                roll = $urandom_range(99);
                if (roll < 5) n_valid = 0;
                else if (roll < 12) n_valid = $urandom_range(4, SOURCES);
                else n_valid = $urandom_range(1, 3);
                push_word(source_header(n_valid));
                repeat (n_valid) begin
                    pt = ($urandom_range(3) != 0);
                    n_blocks = (n_valid > 3) ? $urandom_range(0, 1) : $urandom_range(0, 3);
                    if (n_blocks == 0) n_words = $urandom_range(0, 3);
                    else n_words = block_payload_words(n_blocks, cfg_block);
                    size = (n_words == 0) ? 0 : 2 * n_words - $urandom_range(0, 1);
                    if (size > 511) size = 511;
                    push_word(event_header(size, pt));
                    add_payload(n_words, n_blocks, cfg_block, 3);
                end
            end
        end
        keep = frag_words.size();
        if ($urandom_range(99) < 10) keep = $urandom_range(1, keep);
        send_fragment(keep);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_reset_settings();
        push_word(source_header(3));
        push_word(event_header(41, 1'b1));
        add_payload(21, 1, BLOCK_RESET, 0);
        push_word(event_header(3, 1'b0));
        add_payload(2, 0, BLOCK_RESET, 0);
        push_word(event_header(0, 1'b1));     // empty pass-through payload
        send_fragment(frag_words.size());
    endtask

    task automatic test_no_valid_source();
        push_word(source_header(0));
        push_word(source_header(1));
        push_word(event_header(2, 1'b1));
        push_word({MARKER_WORD, 32'h0000_0000});
        send_fragment(frag_words.size());
        push_word(64'hffff_ffff_ffff_ffff);
        send_fragment(frag_words.size());
        push_word(64'h0000_0000_0000_0000);
        send_fragment(frag_words.size());
    endtask

    task automatic test_channel_runs();
        set_config(3, 5);
        push_word(source_header(3));
        push_word(event_header(8, 1'b1));
        push_word({MARKER_WORD, 32'h0000_0000});
        // The second marker arrives mid-run and starts a new one.
        push_word({32'hffff_fffe, MARKER_WORD});
        push_word({32'h1234_5678, 32'h9abc_def0});
        push_word({32'h0f0f_0f0f, 32'h5555_aaaa});
        // This payload ends while its run is still open.
        push_word(event_header(4, 1'b1));
        push_word({32'h0bad_cafe, MARKER_WORD});
        push_word({32'h0000_0001, 32'h0000_0002});
        push_word(event_header(5, 1'b1));
        add_payload(3, 0, 5, 0);
        send_fragment(frag_words.size());
    endtask

    task automatic test_cut_short();
        push_word(source_header(2));
        push_word(event_header(20, 1'b1));
        add_payload(3, 1, 5, 0);
        send_fragment(frag_words.size());
        push_word(source_header(1));
        push_word(event_header(0, 1'b1));
        send_fragment(frag_words.size());
        push_word(source_header(4));
        send_fragment(frag_words.size());
        push_word(source_header(1));
        push_word(event_header(9, 1'b0));
        add_payload(2, 0, 5, 0);
        send_fragment(frag_words.size());
    endtask

    task automatic test_zero_settings();
        set_config(0, 0);
        push_word(source_header(1));
        push_word(event_header(8, 1'b1));
        add_payload(4, 2, 3, 10);
        send_fragment(frag_words.size());
    endtask

    task automatic test_extreme_settings();
        set_config(63, 63);
        push_word(source_header(1));
        push_word(event_header(66, 1'b1));
        add_payload(33, 1, 63, 0);
        send_fragment(frag_words.size());
        set_config(1, 1);
        push_word(source_header(2));
        push_word(event_header(8, 1'b1));
        add_payload(4, 0, 1, 30);
        push_word(event_header(7, 1'b0));
        add_payload(4, 0, 1, 0);
        send_fragment(frag_words.size());
    endtask

    // A full-size payload that is almost all markers drives the count to 255
    // before the end of the fragment cuts it short.
    task automatic test_marker_saturation();
        logic [63:0] w;
        logic [31:0] half;
        set_config(2, 2);
        push_word(source_header(1));
        push_word(event_header(511, 1'b1));
        for (int h = 0; h < 280; h++) begin
            half = (h % 40 == 39) ? {1'b0, 31'($urandom)} : MARKER_WORD;
            if (h % 2 == 0) begin
                w[63:32] = half;
            end else begin
                w[31:0] = half;
                push_word(w);
            end
        end
        send_fragment(frag_words.size());
    endtask

    task automatic test_backpressure();
        set_config(CHANNELS_RESET, BLOCK_RESET);
        hold_off_cycles = 400;
        push_word(source_header(2));
        repeat (2) begin
            push_word(event_header(42, 1'b1));
            add_payload(21, 1, BLOCK_RESET, 0);
        end
        send_fragment(frag_words.size());
    endtask

    task automatic test_random_traffic();
        int idle_modes[4]  = '{0, 48, 0, 10};
        int stall_modes[4] = '{0, 0, 48, 10};
        int start;
        for (int p = 0; p < 4; p++) begin
            case (p)
                0: set_config(CHANNELS_RESET, BLOCK_RESET);
                1: set_config(3, 5);
                2: set_config($urandom_range(1, 63), $urandom_range(1, 63));
                default: set_config($urandom_range(1, 8), $urandom_range(1, 8));
            endcase
            send_idle_pct = idle_modes[p];
            stall_pct     = stall_modes[p];
            start = words_sent;
            while (words_sent - start < PHASE_WORDS) random_fragment();
        end
        send_idle_pct = 0;
        stall_pct     = 0;
    endtask

    initial begin
        reset_framing();
        cfg_channels = CHANNELS_RESET;
        cfg_block    = BLOCK_RESET;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_settings();
        test_no_valid_source();
        test_channel_runs();
        test_cut_short();
        test_zero_settings();
        test_extreme_settings();
        test_marker_saturation();
        test_backpressure();
        test_random_traffic();

        wait_idle();
        if (errors == 0) begin
            $display("daq_subpacket_deframer regression: pass");
        end else begin
            $display("daq_subpacket_deframer regression: fail");
        end
        $finish;
    end

endmodule

// ----- daq_subpacket_deframer.f -----
+incdir+design
design/dsd_pkg.sv
design/dsd_lane.sv
design/dsd_result_fifo.sv
design/daq_subpacket_deframer.sv
tb/daq_subpacket_deframer_test.sv
